FILE: sv/base64url_stream_encoder_unit_defines.svh
// assertion macros shared by the encoder rtl
`ifndef BASE64URL_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BSENC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BSENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bsenc_pkg.sv
// shared types, constants and the character table of the encoder
package bsenc_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int CAP_W           = 16;
    localparam int TOTAL_W         = 16;
    localparam int CHAR_W          = 7;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // one group request from the front to the back
    typedef struct packed {
        logic [23:0] chunk;
        logic [2:0]  nchars;
        logic        last;
        logic        err;
    } grp_cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // url-safe alphabet lookup for one sextet
    function automatic logic [CHAR_W-1:0] b64url_char(input logic [5:0] sx);
        logic [7:0] c;
        c = 8'd0;
        case (sx) inside
            [6'd0:6'd25]:  c = 8'd65 + {2'b00, sx};
            [6'd26:6'd51]: c = 8'd71 + {2'b00, sx};
            [6'd52:6'd61]: c = {2'b00, sx} - 8'd4;
            6'd62:         c = 8'd45;
            default:       c = 8'd95;
        endcase
        return c[CHAR_W-1:0];
    endfunction

endpackage

FILE: sv/bsenc_front.sv
// front part: byte gathering, capacity checks, discard state, group requests
module bsenc_front
    import bsenc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CAP_W-1:0]       cfg_wdata,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output logic                   in_ready,
    input  q_stat_t                q_stat,
    output logic                   push,
    output grp_cmd_t               push_cmd,
    output logic [LENGTH_BITS-1:0] push_base
);

    localparam int CMP_W = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 1;

    logic [CAP_W-1:0]       capacity_reg;
    logic [15:0]            held_bytes_reg, held_bytes_next;
    logic [1:0]             held_count_reg, held_count_next;
    logic [LENGTH_BITS-1:0] char_count_reg, char_count_next;
    logic                   discarding_reg, discarding_next;

    logic             accept;
    logic [1:0]       nbytes;
    logic [2:0]       nchars;
    logic [23:0]      chunk;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cap_ext;
    logic             grp_fail;
    logic             fin_fail;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // group assembly
    assign nbytes  = held_count_reg + 2'd1;
    assign nchars  = {1'b0, nbytes} + 3'd1;
    assign cnt_ext = CMP_W'(char_count_reg);
    assign cap_ext = CMP_W'(capacity_reg);

    always_comb
    begin
        case (nbytes)
            2'd1:    chunk = {in_byte, 16'h0000};
            2'd2:    chunk = {held_bytes_reg[7:0], in_byte, 8'h00};
            default: chunk = {held_bytes_reg, in_byte};
        endcase
    end

    // capacity checks
    assign grp_fail = (held_count_reg == 2'd0) && ((cnt_ext + CMP_W'(4)) > cap_ext);
    assign fin_fail = in_last && ((cnt_ext + CMP_W'(nchars)) >= cap_ext);

    // next state and group request
    always_comb
    begin
        held_bytes_next  = held_bytes_reg;
        held_count_next  = held_count_reg;
        char_count_next  = char_count_reg;
        discarding_next  = discarding_reg;
        push             = 1'b0;
        push_base        = char_count_reg;
        push_cmd.chunk   = chunk;
        push_cmd.nchars  = nchars;
        push_cmd.last    = in_last;
        push_cmd.err     = 1'b0;
        if (accept)
        begin
            if (discarding_reg)
            begin
                if (in_last)
                begin
                    discarding_next = 1'b0;
                    char_count_next = '0;
                    held_count_next = 2'd0;
                end
            end
            else if (grp_fail)
            begin
                push            = 1'b1;
                push_cmd.chunk  = 24'h000000;
                push_cmd.nchars = 3'd1;
                push_cmd.last   = 1'b1;
                push_cmd.err    = 1'b1;
                held_count_next = 2'd0;
                if (in_last)
                begin
                    char_count_next = '0;
                end
                else
                begin
                    discarding_next = 1'b1;
                end
            end
            else if ((nbytes != 2'd3) && !in_last)
            begin
                held_bytes_next = {held_bytes_reg[7:0], in_byte};
                held_count_next = nbytes;
            end
            else
            begin
                push            = 1'b1;
                held_count_next = 2'd0;
                if (fin_fail)
                begin
                    push_cmd.chunk  = 24'h000000;
                    push_cmd.nchars = 3'd1;
                    push_cmd.err    = 1'b1;
                end
                if (in_last)
                begin
                    char_count_next = '0;
                end
                else
                begin
                    char_count_next = char_count_reg + LENGTH_BITS'(nchars);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            held_count_reg <= 2'd0;
            char_count_reg <= '0;
            discarding_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            held_count_reg <= held_count_next;
            char_count_reg <= char_count_next;
            discarding_reg <= discarding_next;
        end
    end

    // pending bytes
    always_ff @(posedge clk)
    begin
        held_bytes_reg <= held_bytes_next;
    end

endmodule

FILE: sv/bsenc_queue.sv
// short request queue between the front and the back
module bsenc_queue
    import bsenc_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output q_stat_t          stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [WIDTH-1:0] entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign stat.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = entries[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/bsenc_back.sv
// back part: serializes each group request into characters, one per cycle while out_ready is high
module bsenc_back
    import bsenc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  q_stat_t                q_stat,
    input  grp_cmd_t               head_cmd,
    input  logic [LENGTH_BITS-1:0] head_base,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   out_last,
    output logic                   out_error,
    output logic [TOTAL_W-1:0]     out_total
);

    localparam int EXT_W = (LENGTH_BITS > TOTAL_W) ? LENGTH_BITS : TOTAL_W;

    grp_cmd_t               cmd_reg;
    logic [LENGTH_BITS-1:0] base_reg;
    logic [1:0]             idx_reg, idx_next;
    logic                   busy_reg, busy_next;

    logic                   final_char;
    logic                   taken;
    logic [5:0]             sextet;
    logic [LENGTH_BITS-1:0] count_now;
    logic [EXT_W-1:0]       count_ext;

    assign final_char = ({1'b0, idx_reg} == (cmd_reg.nchars - 3'd1));
    assign taken      = busy_reg && out_ready;
    assign pop        = !q_stat.empty && (!busy_reg || (taken && final_char));

    // sequencing over the characters of the current group
    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (taken)
        begin
            if (final_char)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // current group payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= head_cmd;
            base_reg <= head_base;
        end
    end

    // sextet pick, msb first
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = cmd_reg.chunk[23:18];
            2'd1:    sextet = cmd_reg.chunk[17:12];
            2'd2:    sextet = cmd_reg.chunk[11:6];
            default: sextet = cmd_reg.chunk[5:0];
        endcase
    end

    // running length, the error result carries the count before it
    assign count_now = cmd_reg.err ? base_reg
                                   : base_reg + LENGTH_BITS'(idx_reg) + LENGTH_BITS'(1);
    assign count_ext = EXT_W'(count_now);

    assign out_valid = busy_reg;
    assign out_char  = cmd_reg.err ? '0 : b64url_char(sextet);
    assign out_last  = cmd_reg.last && final_char;
    assign out_error = cmd_reg.err;
    assign out_total = count_ext[TOTAL_W-1:0];

endmodule

FILE: sv/base64url_stream_encoder_unit.sv
// top level of the unpadded url-safe base64 stream encoder
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] data_byte, tlast last_byte
//  m_*      out  m_tvalid/m_tready  tdata[6:0] out_char, [22:7] total_length,
//                                   tlast last_char, tuser error
//  cfg_*    in   cfg_we             cfg_wdata output_capacity
//
// a byte is taken every cycle while the group queue has room; the back
// emits one character per cycle while m_tready is high, so a full group of
// three bytes yields four characters. reset clears the held byte count,
// the character count, discard state and the queue; capacity returns to
// 65535. output stalls fill the queue and then hold s_tready low.
module base64url_stream_encoder_unit
    import bsenc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // out_char, total_length, zero fill
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // error
);

`include "base64url_stream_encoder_unit_defines.svh"

    localparam int Q_W = $bits(grp_cmd_t) + LENGTH_BITS;

    q_stat_t                q_stat;
    logic                   push;
    grp_cmd_t               push_cmd;
    logic [LENGTH_BITS-1:0] push_base;
    logic                   pop;
    logic [Q_W-1:0]         head_data;
    grp_cmd_t               head_cmd;
    logic [LENGTH_BITS-1:0] head_base;
    logic [CHAR_W-1:0]      out_char;
    logic [TOTAL_W-1:0]     out_total;
    logic                   out_error;

    // front: gather bytes and check capacity
    bsenc_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_base (push_base)
    );

    // group request queue
    bsenc_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({push_base, push_cmd}),
        .rd_en   (pop),
        .rd_data (head_data),
        .stat    (q_stat)
    );

    assign head_cmd  = head_data[$bits(grp_cmd_t)-1:0];
    assign head_base = head_data[Q_W-1:$bits(grp_cmd_t)];

    // back: character serializer
    bsenc_back #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_cmd  (head_cmd),
        .head_base (head_base),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_error (out_error),
        .out_total (out_total)
    );

    // output packing
    assign m_tdata = {1'b0, out_total, out_char};
    assign m_tuser = out_error;

    // checks
    `BSENC_ASSERT_NOW(a_err_is_final, m_tvalid && out_error, m_tlast && (out_char == '0), "error result must be final with a zero character")
    `BSENC_ASSERT_NOW(a_char_nonzero, m_tvalid && !out_error, out_char != '0, "character result carries a zero code")
    `BSENC_ASSERT_NEXT(a_idle_stays, !m_tvalid && q_stat.empty, !m_tvalid, "output became valid with no queued request")

endmodule
